/* hw/rtl/ldps_pkg.sv */
// ----------------------------------------------------------------------------
// Log-domain dot-product scorer package
// Shared widths, codes, record types and the lane antilog function.
// ----------------------------------------------------------------------------
package ldps_pkg;

   // Field widths of the channels.
   localparam int GROUP_W = 6;
   localparam int LOG_W   = 8;
   localparam int SCORE_W = 27;
   localparam int INDEX_W = 16;

   // Lane layout: four logs per item, element = group * LANES + lane.
   localparam int LANES  = 4;
   localparam int LANE_W = $clog2(LANES);

   // Fixed-point split of a log sum: low F_BITS are the fraction.
   localparam int F_BITS = 3;

   // A term is at most 15 << 15, and four of them fit in TSUM_W bits.
   localparam int TERM_W = 19;
   localparam int TSUM_W = TERM_W + LANE_W;

   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   // Work queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLEVEL_W    = QPTR_W + 1;

   typedef enum logic {
      OP_LOAD_QUERY = 1'b0,
      OP_SCORE      = 1'b1
   } opcode_type;

   typedef logic [LANES-1:0][LOG_W-1:0] lane_logs_type;

   // One unit of work for the back end.
   typedef struct packed {
      logic          is_score;
      logic          clear_count;
      logic          last;
      logic [LANES-1:0] lane_on;
      lane_logs_type qlog;
      lane_logs_type dlog;
   } work_type;

   // Queue status seen by the front end.
   typedef struct packed {
      logic                not_empty;
      logic [QLEVEL_W-1:0] level;
   } queue_status_type;

   // Antilog of one lane: (1.f) scaled by 2^k, k the signed integer part.
   function automatic logic [TERM_W-1:0] lane_term(input logic [LOG_W-1:0] qlog,
                                                   input logic [LOG_W-1:0] dlog);
      logic [LOG_W-1:0]        s;
      logic [F_BITS:0]         mant;
      logic [LOG_W-F_BITS-1:0] k;
      logic [LOG_W-F_BITS-1:0] rsh;
      logic [TERM_W-1:0]       wide;
      s    = qlog + dlog;
      mant = {1'b1, s[F_BITS-1:0]};
      k    = s[LOG_W-1:F_BITS];
      rsh  = '0 - k;
      wide = TERM_W'(mant);
      if (k[LOG_W-F_BITS-1]) begin
         lane_term = wide >> rsh;
      end else begin
         lane_term = wide << k[LOG_W-F_BITS-2:0];
      end
   endfunction

endpackage

/* hw/rtl/ldps_channels.sv */
// ----------------------------------------------------------------------------
// Log-domain dot-product scorer channels
// Valid/ready interfaces for the request and response items.
// ----------------------------------------------------------------------------
interface ldps_req_if;
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [ldps_pkg::GROUP_W-1:0] group_index;
   logic signed [ldps_pkg::LOG_W-1:0] value_0;
   logic signed [ldps_pkg::LOG_W-1:0] value_1;
   logic signed [ldps_pkg::LOG_W-1:0] value_2;
   logic signed [ldps_pkg::LOG_W-1:0] value_3;
   logic                        last_group;

   modport source (output valid, opcode, group_index, value_0, value_1, value_2,
                   value_3, last_group, input ready);
   modport sink   (input valid, opcode, group_index, value_0, value_1, value_2,
                   value_3, last_group, output ready);
endinterface

interface ldps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ldps_pkg::SCORE_W-1:0] score;
   logic [ldps_pkg::INDEX_W-1:0] vector_index;

   modport source (output valid, score, vector_index, input ready);
   modport sink   (input valid, score, vector_index, output ready);
endinterface

/* hw/rtl/ldps_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ldps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ldps_front.sv */
// ----------------------------------------------------------------------------
// Scorer front end
// Accepts items, writes query logs, reads query logs for scoring items and
// pushes the resulting work into the queue in the cycle after acceptance.
// ----------------------------------------------------------------------------
module ldps_front #(
   parameter int DIM = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   ldps_req_if.sink                   req_bus,
   input  ldps_pkg::queue_status_type queue_status,
   output logic                       push_valid,
   output ldps_pkg::work_type         push_work
);

   localparam int ROWS  = (DIM + ldps_pkg::LANES - 1) / ldps_pkg::LANES;
   localparam int ROW_W = $clog2(ROWS);

   logic                              accept;
   logic                              is_score;
   logic [ldps_pkg::LANES-1:0]        lane_on;
   ldps_pkg::lane_logs_type           in_logs;
   ldps_pkg::lane_logs_type           qlog_rd;
   logic [ROW_W-1:0]                  row_addr;
   logic [ldps_pkg::QLEVEL_W-1:0]     pending;

   logic                              f1_valid_ff, f1_valid_in;
   ldps_pkg::work_type                f1_work_ff, f1_work_in;

   // Space check: queue level plus the item in the read stage.
   assign pending         = queue_status.level + ldps_pkg::QLEVEL_W'(f1_valid_ff);
   assign req_bus.ready   = pending < ldps_pkg::QLEVEL_W'(ldps_pkg::QUEUE_DEPTH);
   assign accept          = req_bus.valid && req_bus.ready;
   assign is_score        = ldps_pkg::opcode_type'(req_bus.opcode) == ldps_pkg::OP_SCORE;
   assign row_addr        = ROW_W'(req_bus.group_index);

   assign in_logs[0] = req_bus.value_0;
   assign in_logs[1] = req_bus.value_1;
   assign in_logs[2] = req_bus.value_2;
   assign in_logs[3] = req_bus.value_3;

   // A lane takes part only if its element lies inside the vector.
   always_comb begin
      for (int l = 0; l < ldps_pkg::LANES; l++) begin
         lane_on[l] = int'({req_bus.group_index, ldps_pkg::LANE_W'(l)}) < DIM;
      end
   end

   // One query bank per lane, one row per group.
   for (genvar g = 0; g < ldps_pkg::LANES; g++) begin : g_bank
      ldps_ram #(
         .WIDTH (ldps_pkg::LOG_W),
         .DEPTH (ROWS)
      ) u_bank (
         .clock   (clock),
         .wr_en   (accept && !is_score && lane_on[g]),
         .wr_addr (row_addr),
         .wr_data (in_logs[g]),
         .rd_en   (accept && is_score),
         .rd_addr (row_addr),
         .rd_data (qlog_rd[g])
      );
   end

   // Classify the accepted item for the read stage.
   always_comb begin
      f1_valid_in            = accept;
      f1_work_in.is_score    = is_score;
      f1_work_in.clear_count = !is_score && (req_bus.group_index == '0);
      f1_work_in.last        = req_bus.last_group;
      f1_work_in.lane_on     = lane_on;
      f1_work_in.qlog        = '0;
      f1_work_in.dlog        = in_logs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_work_ff <= f1_work_in;
      end
   end

   // Only scoring items and counter clears have work left for the back end.
   always_comb begin
      push_valid     = f1_valid_ff && (f1_work_ff.is_score || f1_work_ff.clear_count);
      push_work      = f1_work_ff;
      push_work.qlog = qlog_rd;
   end

endmodule

/* hw/rtl/ldps_queue.sv */
// ----------------------------------------------------------------------------
// Scorer work queue
// Small FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ldps_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  ldps_pkg::work_type         push_work,
   input  logic                       pop,
   output ldps_pkg::queue_status_type status,
   output ldps_pkg::work_type         head_work
);

   ldps_pkg::work_type               mem_ff [ldps_pkg::QUEUE_DEPTH];
   logic [ldps_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ldps_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ldps_pkg::QLEVEL_W-1:0]    level_ff, level_in;

   // Pointer and level update.
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff + ldps_pkg::QLEVEL_W'(push_valid)
                  - ldps_pkg::QLEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_work;
      end
   end

   assign status.not_empty = level_ff != '0;
   assign status.level     = level_ff;
   assign head_work        = mem_ff[rd_ptr_ff];

endmodule

/* hw/rtl/ldps_back.sv */
// ----------------------------------------------------------------------------
// Scorer back end
// Computes the lane antilog terms, accumulates them per vector and holds
// finished results in an output register.
// ----------------------------------------------------------------------------
module ldps_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ldps_pkg::queue_status_type queue_status,
   input  ldps_pkg::work_type         head_work,
   output logic                       pop,
   ldps_rsp_if.source                 rsp_bus
);

   logic [ldps_pkg::TSUM_W-1:0]   term_sum;
   logic                          out_free;
   logic                          emit;
   logic                          b1_advance;
   logic [ldps_pkg::SCORE_W:0]    acc_total;
   logic [ldps_pkg::SCORE_W-1:0]  acc_sat;

   logic                          b1_valid_ff, b1_valid_in;
   logic                          b1_is_score_ff, b1_clear_ff, b1_last_ff;
   logic [ldps_pkg::TSUM_W-1:0]   b1_sum_ff;

   logic [ldps_pkg::SCORE_W-1:0]  acc_ff, acc_in;
   logic [ldps_pkg::INDEX_W-1:0]  count_ff, count_in;
   logic                          out_valid_ff, out_valid_in;
   logic [ldps_pkg::SCORE_W-1:0]  out_score_ff;
   logic [ldps_pkg::INDEX_W-1:0]  out_index_ff;

   // Sum of the active lane terms of the queue head.
   always_comb begin
      term_sum = '0;
      for (int l = 0; l < ldps_pkg::LANES; l++) begin
         if (head_work.lane_on[l]) begin
            term_sum = term_sum + ldps_pkg::TSUM_W'(
               ldps_pkg::lane_term(head_work.qlog[l], head_work.dlog[l]));
         end
      end
   end

   // Handshake between the term stage, the accumulator and the output.
   assign out_free    = !out_valid_ff || rsp_bus.ready;
   assign emit        = b1_is_score_ff && b1_last_ff;
   assign b1_advance  = b1_valid_ff && (!emit || out_free);
   assign pop         = queue_status.not_empty && (!b1_valid_ff || b1_advance);
   assign b1_valid_in = pop || (b1_valid_ff && !b1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= b1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b1_is_score_ff <= head_work.is_score;
         b1_clear_ff    <= head_work.clear_count;
         b1_last_ff     <= head_work.last;
         b1_sum_ff      <= term_sum;
      end
   end

   // Saturating accumulate; terms are never negative, so one clamp suffices.
   assign acc_total = {1'b0, acc_ff} + (ldps_pkg::SCORE_W + 1)'(b1_sum_ff);
   assign acc_sat   = acc_total[ldps_pkg::SCORE_W] ? ldps_pkg::SCORE_MAX
                                                   : acc_total[ldps_pkg::SCORE_W-1:0];

   // Accumulator, vector counter and output valid.
   always_comb begin
      acc_in       = acc_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (b1_advance) begin
         if (b1_is_score_ff) begin
            if (b1_last_ff) begin
               acc_in       = '0;
               count_in     = count_ff + 1'b1;
               out_valid_in = 1'b1;
            end else begin
               acc_in = acc_sat;
            end
         end else if (b1_clear_ff) begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload is captured when a vector completes.
   always_ff @(posedge clock) begin
      if (b1_advance && emit) begin
         out_score_ff <= acc_sat;
         out_index_ff <= count_ff;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.score        = out_score_ff;
   assign rsp_bus.vector_index = out_index_ff;

endmodule

/* hw/rtl/log_domain_dot_product_scorer_core.sv */
// ----------------------------------------------------------------------------
// Log-domain dot-product scorer
// Scores streamed database vectors against a stored query vector with a
// Mitchell antilog approximation of each lane product.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_bus   in         opcode, group_index, value_0..value_3, last_group
//  rsp_bus   out        score, vector_index (one per vector marked last)
//
// One item is accepted per cycle while the work queue has room. A result
// for a vector travels from the accept of its last group, where the query
// read happens, through the work queue, the term stage and the accumulator
// into the output register.
// Reset is synchronous and clears the queue, accumulator, vector counter
// and valid flags; the query store holds no reset value.
// A stalled response fills the four-entry work queue; req_bus.ready drops
// when its level plus the read-stage item reach four; query loads go on until then.
// ----------------------------------------------------------------------------
module log_domain_dot_product_scorer_core #(
   parameter int DIM = 256
) (
   input  logic        clock,
   input  logic        reset,
   ldps_req_if.sink    req_bus,
   ldps_rsp_if.source  rsp_bus
);

   logic                       push_valid;
   ldps_pkg::work_type         push_work;
   logic                       pop;
   ldps_pkg::queue_status_type queue_status;
   ldps_pkg::work_type         head_work;

   // Accept, query store and classification.
   ldps_front #(
      .DIM (DIM)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_work    (push_work)
   );

   // Decoupling queue.
   ldps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_work  (push_work),
      .pop        (pop),
      .status     (queue_status),
      .head_work  (head_work)
   );

   // Terms, accumulation and result output.
   ldps_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_work    (head_work),
      .pop          (pop),
      .rsp_bus      (rsp_bus)
   );

endmodule

/* hw/rtl/ldps_checker.sv */
// ----------------------------------------------------------------------------
// Scorer port checker
// Watches the top-level ports for reset, stall and drain behavior.
// ----------------------------------------------------------------------------
module ldps_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ldps_pkg::SCORE_W-1:0] rsp_score,
   input logic [ldps_pkg::INDEX_W-1:0] rsp_vector_index
);

   // A stalled result keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_score)
                                  && $stable(rsp_vector_index))
      else $error("response changed while stalled");

   // Reset empties the block: ready at once and no result valid.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid ##1 !rsp_valid)
      else $error("block not empty after reset");

   // A draining response side reopens the request side in the cycle after.
   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |=> req_ready)
      else $error("request side stalled while response side drains");

   // A pending request never sees ready drop without back pressure.
   a_no_spurious_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> !$past(rsp_ready))
      else $error("request stalled without response back pressure");

endmodule

bind log_domain_dot_product_scorer_core ldps_checker u_ldps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_score        (rsp_bus.score),
   .rsp_vector_index (rsp_bus.vector_index)
);
